// File: hw/rtl/lru_block_cache_tag_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU block cache tag engine
// Immediate-style wrappers around concurrent properties.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_CACHE_TAG_ENGINE_MACROS_SVH
`define LRU_BLOCK_CACHE_TAG_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: hw/rtl/lbcte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcte_pkg
// Types and constants shared by the tag engine controller and datapath.
// ----------------------------------------------------------------------------
package lbcte_pkg;

   localparam int ADDR_W     = 48;
   localparam int DEV_W      = 3;
   localparam int CNT_W      = 10;
   localparam int SLOT_PW    = 10;
   localparam int OFF_W      = 7;
   localparam int LSZ_W      = 8;
   localparam int SHIFT_W    = 3;
   localparam int CAP_W      = 11;
   localparam int SEGN_W     = 6;
   localparam int MAX_SEGMENTS = 33;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 3'd4;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd7;
   localparam logic [CAP_W-1:0]   CAP_RESET   = 11'd1024;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_BAD     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT    = 2'd2;

   typedef enum logic [3:0] {
      ACT_HIT          = 4'd0,
      ACT_MISS_FREE    = 4'd1,
      ACT_MISS_EVICT   = 4'd2,
      ACT_EDGE_BYPASS  = 4'd3,
      ACT_DIS_BYPASS   = 4'd4,
      ACT_WR_UPDATED   = 4'd5,
      ACT_WR_UNCACHED  = 4'd6,
      ACT_RELEASED     = 4'd7,
      ACT_REJECTED     = 4'd8
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_REL_RD,
      ST_REL_CHK,
      ST_SEG,
      ST_SCAN,
      ST_DECIDE,
      ST_UNLINK_RD,
      ST_UNLINK_WR,
      ST_PUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [DEV_W-1:0]  dev;
      logic [ADDR_W-1:0] line;
   } tag_body_type;

   typedef struct packed {
      logic         valid;
      tag_body_type body;
   } tag_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       seg_latch;
      logic       scan;
      logic       take_hit;
      logic       fill_free;
      logic       evict;
      logic       rel_commit;
      logic       res_rslot;
      logic       set_action;
      action_type action;
      logic       unlink;
      logic       push;
      logic       emit;
      logic       advance;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_release;
      logic bad;
      logic rslot_ok;
      logic rel_valid;
      logic wr_op;
      logic enable;
      logic edge_hit;
      logic scan_done;
      logic hit_found;
      logic free_ok;
      logic list_empty;
      logic out_free;
      logic last;
   } stat_type;

endpackage

// File: hw/rtl/lbcte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbcte_ctrl
// Sequencer: segment walk, tag scan, recency list steps and result handoff.
// ----------------------------------------------------------------------------
module lbcte_ctrl
   import lbcte_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (st.clear_done) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (st.is_release) state_in = st.rslot_ok ? ST_REL_RD : ST_EMIT;
            else if (st.bad) state_in = ST_EMIT;
            else state_in = ST_SEG;
         end
         ST_REL_RD:    state_in = ST_REL_CHK;
         ST_REL_CHK:   state_in = st.rel_valid ? ST_UNLINK_RD : ST_EMIT;
         ST_SEG: begin
            if (!st.enable || (!st.wr_op && st.edge_hit)) state_in = ST_EMIT;
            else state_in = ST_SCAN;
         end
         ST_SCAN:      if (st.scan_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (st.hit_found) state_in = ST_UNLINK_RD;
            else if (st.wr_op) state_in = ST_EMIT;
            else if (st.free_ok) state_in = ST_PUSH;
            else if (!st.list_empty) state_in = ST_UNLINK_RD;
            else state_in = ST_EMIT;
         end
         ST_UNLINK_RD: state_in = ST_UNLINK_WR;
         ST_UNLINK_WR: state_in = st.is_release ? ST_EMIT : ST_PUSH;
         ST_PUSH:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (st.out_free) state_in = st.last ? ST_IDLE : ST_SEG;
         end
         default:      state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DECODE: begin
            if (st.is_release) begin
               if (!st.rslot_ok) begin
                  cmd.set_action = 1'b1;
                  cmd.action = ACT_REJECTED;
                  cmd.res_rslot = 1'b1;
               end
            end else if (st.bad) begin
               cmd.set_action = 1'b1;
               cmd.action = ACT_REJECTED;
            end
         end
         ST_REL_RD: ;
         ST_REL_CHK: begin
            cmd.set_action = 1'b1;
            cmd.res_rslot = 1'b1;
            if (st.rel_valid) begin
               cmd.rel_commit = 1'b1;
               cmd.action = ACT_RELEASED;
            end else begin
               cmd.action = ACT_REJECTED;
            end
         end
         ST_SEG: begin
            cmd.seg_latch = 1'b1;
            if (!st.enable) begin
               cmd.set_action = 1'b1;
               cmd.action = st.wr_op ? ACT_WR_UNCACHED : ACT_DIS_BYPASS;
            end else if (!st.wr_op && st.edge_hit) begin
               cmd.set_action = 1'b1;
               cmd.action = ACT_EDGE_BYPASS;
            end
         end
         ST_SCAN: cmd.scan = 1'b1;
         ST_DECIDE: begin
            cmd.set_action = 1'b1;
            if (st.hit_found) begin
               cmd.take_hit = 1'b1;
               cmd.action = st.wr_op ? ACT_WR_UPDATED : ACT_HIT;
            end else if (st.wr_op) begin
               cmd.action = ACT_WR_UNCACHED;
            end else if (st.free_ok) begin
               cmd.fill_free = 1'b1;
               cmd.action = ACT_MISS_FREE;
            end else if (!st.list_empty) begin
               cmd.evict = 1'b1;
               cmd.action = ACT_MISS_EVICT;
            end else begin
               cmd.action = ACT_DIS_BYPASS;
            end
         end
         ST_UNLINK_RD: ;
         ST_UNLINK_WR: cmd.unlink = 1'b1;
         ST_PUSH:      cmd.push = 1'b1;
         ST_EMIT: begin
            cmd.emit = st.out_free;
            cmd.advance = st.out_free && !st.last;
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/lbcte_dpath.sv
`timescale 1ns / 1ps
`include "lru_block_cache_tag_engine_macros.svh"
// ----------------------------------------------------------------------------
// lbcte_dpath
// Tag store, recency list, segment arithmetic, settings and result register.
// ----------------------------------------------------------------------------
module lbcte_dpath
   import lbcte_pkg::*;
#(
   parameter int LINE_SLOTS          = 1024,
   parameter int DEVICE_COUNT        = 8,
   parameter int MAX_REQUEST_SECTORS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              st,
   input  logic [1:0]            req_opcode,
   input  logic [DEV_W-1:0]      req_device,
   input  logic [ADDR_W-1:0]     req_start_sector,
   input  logic [CNT_W-1:0]      req_sector_count,
   input  logic [ADDR_W-1:0]     req_device_capacity,
   input  logic [SLOT_PW-1:0]    req_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_action,
   output logic [ADDR_W-1:0]     rsp_line_number,
   output logic [OFF_W-1:0]      rsp_offset_in_line,
   output logic [CNT_W-1:0]      rsp_sector_take,
   output logic [SLOT_PW-1:0]    rsp_slot_res,
   output logic [DEV_W-1:0]      rsp_evicted_device,
   output logic [ADDR_W-1:0]     rsp_evicted_line_number,
   output logic                  rsp_last_of_request,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = $clog2(LINE_SLOTS);
   localparam int SCAN_W = $clog2(LINE_SLOTS + 1);

   // settings
   logic              cfg_enable_ff;
   logic [CAP_W-1:0]  cfg_capacity_ff;
   logic [SHIFT_W-1:0] cfg_shift_ff;

   // request
   logic [1:0]         op_ff;
   logic [DEV_W-1:0]   dev_ff;
   logic [ADDR_W-1:0]  cur_ff;
   logic [CNT_W-1:0]   remaining_ff;
   logic [ADDR_W-1:0]  devcap_ff;
   logic [SLOT_PW-1:0] rslot_ff;
   logic [SEGN_W-1:0]  seg_n_ff;
   logic               single_ff;

   // current result
   action_type         act_ff;
   logic [ADDR_W-1:0]  line_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [CNT_W-1:0]   take_ff;
   logic [SLOT_PW-1:0] res_slot_ff;
   logic [DEV_W-1:0]   edev_ff;
   logic [ADDR_W-1:0]  eline_ff;
   logic [SLOT_W-1:0]  target_ff;

   // output register
   logic               rsp_valid_ff;
   action_type         rsp_action_ff;
   logic [ADDR_W-1:0]  rsp_line_ff;
   logic [OFF_W-1:0]   rsp_off_ff;
   logic [CNT_W-1:0]   rsp_take_ff;
   logic [SLOT_PW-1:0] rsp_slot_ff;
   logic [DEV_W-1:0]   rsp_edev_ff;
   logic [ADDR_W-1:0]  rsp_eline_ff;
   logic               rsp_last_ff;

   // recency list and occupancy
   logic [SLOT_W-1:0]  head_ff;
   logic [SLOT_W-1:0]  tail_ff;
   logic               recency_empty_ff;
   logic [SCAN_W-1:0]  lines_in_use_ff;
   logic [SLOT_W-1:0]  clr_cnt_ff;

   // scan
   logic [SCAN_W-1:0]  scan_idx_ff;
   logic               rd_live_ff;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic               hit_found_ff;
   logic [SLOT_W-1:0]  hit_idx_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_idx_ff;
   tag_body_type       tail_tag_ff;

   // memories
   tag_type            tag_mem [LINE_SLOTS];
   logic [SLOT_W-1:0]  prev_mem [LINE_SLOTS];
   logic [SLOT_W-1:0]  next_mem [LINE_SLOTS];
   tag_type            tag_q;
   logic [SLOT_W-1:0]  prev_q;
   logic [SLOT_W-1:0]  next_q;

   logic               tag_we;
   logic [SLOT_W-1:0]  tag_wa;
   tag_type            tag_wd;
   logic [SLOT_W-1:0]  tag_ra;
   logic               next_we;
   logic [SLOT_W-1:0]  next_wa;
   logic [SLOT_W-1:0]  next_wd;
   logic               prev_we;
   logic [SLOT_W-1:0]  prev_wa;
   logic [SLOT_W-1:0]  prev_wd;

   // segment arithmetic
   logic [SHIFT_W-1:0] sh;
   logic [LSZ_W-1:0]   lsz;
   logic [ADDR_W-1:0]  lmask;
   logic [ADDR_W-1:0]  seg_line;
   logic [ADDR_W-1:0]  lstart;
   logic [OFF_W-1:0]   seg_off;
   logic [CNT_W-1:0]   room;
   logic [CNT_W-1:0]   seg_take;
   logic [ADDR_W:0]    lend;
   logic [CNT_W-1:0]   rem_after;
   logic [SLOT_W-1:0]  rslot_idx;
   logic               issue;
   logic               hit_here;
   logic [31:0]        cap_lim;

   always_comb begin
      sh        = (cfg_shift_ff < MIN_SHIFT) ? MIN_SHIFT : cfg_shift_ff;
      lsz       = LSZ_W'(1) << sh;
      lmask     = ADDR_W'(lsz) - ADDR_W'(1);
      seg_line  = cur_ff >> sh;
      lstart    = cur_ff & ~lmask;
      seg_off   = OFF_W'(cur_ff & lmask);
      room      = CNT_W'(lsz) - CNT_W'(seg_off);
      seg_take  = (room > remaining_ff) ? remaining_ff : room;
      lend      = {1'b0, lstart} + (ADDR_W+1)'(lsz);
      rem_after = remaining_ff - take_ff;
      rslot_idx = SLOT_W'(rslot_ff);
      issue     = cmd.scan && (scan_idx_ff < SCAN_W'(LINE_SLOTS));
      tag_ra    = issue ? scan_idx_ff[SLOT_W-1:0] : rslot_idx;
      hit_here  = rd_live_ff && tag_q.valid && (tag_q.body.dev == dev_ff)
                  && (tag_q.body.line == line_ff);
      cap_lim   = (32'(cfg_capacity_ff) > LINE_SLOTS) ? LINE_SLOTS : 32'(cfg_capacity_ff);
   end

   always_comb begin
      st.clear_done = (clr_cnt_ff == SLOT_W'(LINE_SLOTS - 1));
      st.is_release = (op_ff == OP_RELEASE);
      st.bad        = (op_ff == OP_BAD) || (remaining_ff == '0)
                      || (32'(remaining_ff) > MAX_REQUEST_SECTORS)
                      || (32'(dev_ff) >= DEVICE_COUNT);
      st.rslot_ok   = (32'(rslot_ff) < LINE_SLOTS);
      st.rel_valid  = tag_q.valid;
      st.wr_op      = (op_ff == OP_WRITE);
      st.enable     = cfg_enable_ff;
      st.edge_hit   = (devcap_ff != '0) && (lend > {1'b0, devcap_ff});
      st.scan_done  = (scan_idx_ff == SCAN_W'(LINE_SLOTS)) && !rd_live_ff;
      st.hit_found  = hit_found_ff;
      st.free_ok    = free_found_ff && (32'(lines_in_use_ff) < cap_lim);
      st.list_empty = recency_empty_ff;
      st.out_free   = !rsp_valid_ff || rsp_ready;
      st.last       = single_ff || (rem_after == '0)
                      || (seg_n_ff == SEGN_W'(MAX_SEGMENTS - 1));
   end

   // memory write ports
   always_comb begin
      tag_we  = 1'b0;
      tag_wa  = '0;
      tag_wd  = '0;
      if (cmd.clear) begin
         tag_we = 1'b1;
         tag_wa = clr_cnt_ff;
      end else if (cmd.fill_free) begin
         tag_we = 1'b1;
         tag_wa = free_idx_ff;
         tag_wd = {1'b1, dev_ff, line_ff};
      end else if (cmd.evict) begin
         tag_we = 1'b1;
         tag_wa = tail_ff;
         tag_wd = {1'b1, dev_ff, line_ff};
      end else if (cmd.rel_commit) begin
         tag_we = 1'b1;
         tag_wa = rslot_idx;
      end

      next_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = '0;
      if (cmd.unlink && !(head_ff == target_ff && tail_ff == target_ff)) begin
         if (target_ff != head_ff) begin
            next_we = 1'b1;
            next_wa = prev_q;
            next_wd = next_q;
         end
         if (target_ff != tail_ff) begin
            prev_we = 1'b1;
            prev_wa = next_q;
            prev_wd = prev_q;
         end
      end else if (cmd.push && !recency_empty_ff) begin
         next_we = 1'b1;
         next_wa = target_ff;
         next_wd = head_ff;
         prev_we = 1'b1;
         prev_wa = head_ff;
         prev_wd = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_wa] <= tag_wd;
      tag_q <= tag_mem[tag_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_q <= next_mem[target_ff];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_q <= prev_mem[target_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_enable_ff    <= 1'b1;
         cfg_capacity_ff  <= CAP_RESET;
         cfg_shift_ff     <= SHIFT_RESET;
         head_ff          <= '0;
         tail_ff          <= '0;
         recency_empty_ff <= 1'b1;
         lines_in_use_ff  <= '0;
         clr_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         rd_live_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ENABLE:   cfg_enable_ff   <= csr_wdata[0];
               CSR_CAPACITY: cfg_capacity_ff <= csr_wdata[CAP_W-1:0];
               CSR_SHIFT:    cfg_shift_ff    <= csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
         rd_live_ff <= issue;
         if (cmd.fill_free) lines_in_use_ff <= lines_in_use_ff + SCAN_W'(1);
         if (cmd.rel_commit && lines_in_use_ff != '0) begin
            lines_in_use_ff <= lines_in_use_ff - SCAN_W'(1);
         end
         if (cmd.unlink) begin
            if (head_ff == target_ff && tail_ff == target_ff) begin
               recency_empty_ff <= 1'b1;
            end else begin
               if (target_ff == head_ff) head_ff <= next_q;
               if (target_ff == tail_ff) tail_ff <= prev_q;
            end
         end
         if (cmd.push) begin
            head_ff <= target_ff;
            if (recency_empty_ff) begin
               tail_ff          <= target_ff;
               recency_empty_ff <= 1'b0;
            end
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_opcode;
         dev_ff       <= req_device;
         cur_ff       <= req_start_sector;
         remaining_ff <= req_sector_count;
         devcap_ff    <= req_device_capacity;
         rslot_ff     <= req_slot;
         seg_n_ff     <= '0;
         single_ff    <= (req_opcode == OP_RELEASE) || (req_opcode == OP_BAD)
                         || (req_sector_count == '0)
                         || (32'(req_sector_count) > MAX_REQUEST_SECTORS)
                         || (32'(req_device) >= DEVICE_COUNT);
         line_ff      <= '0;
         off_ff       <= '0;
         take_ff      <= '0;
      end
      if (cmd.seg_latch) begin
         line_ff       <= seg_line;
         off_ff        <= seg_off;
         take_ff       <= seg_take;
         scan_idx_ff   <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (issue) scan_idx_ff <= scan_idx_ff + SCAN_W'(1);
      rd_idx_ff <= tag_ra;
      if (hit_here && !hit_found_ff) begin
         hit_found_ff <= 1'b1;
         hit_idx_ff   <= rd_idx_ff;
      end
      if (rd_live_ff && !tag_q.valid && !free_found_ff) begin
         free_found_ff <= 1'b1;
         free_idx_ff   <= rd_idx_ff;
      end
      if (rd_live_ff && rd_idx_ff == tail_ff) tail_tag_ff <= tag_q.body;
      if (cmd.set_action) act_ff <= cmd.action;
      if (cmd.take_hit) res_slot_ff <= SLOT_PW'(hit_idx_ff);
      else if (cmd.fill_free) res_slot_ff <= SLOT_PW'(free_idx_ff);
      else if (cmd.evict) res_slot_ff <= SLOT_PW'(tail_ff);
      else if (cmd.res_rslot) res_slot_ff <= rslot_ff;
      else if (cmd.set_action) res_slot_ff <= '0;
      if (cmd.evict) begin
         edev_ff  <= tail_tag_ff.dev;
         eline_ff <= tail_tag_ff.line;
      end else if (cmd.set_action) begin
         edev_ff  <= '0;
         eline_ff <= '0;
      end
      if (cmd.take_hit) target_ff <= hit_idx_ff;
      else if (cmd.fill_free) target_ff <= free_idx_ff;
      else if (cmd.evict) target_ff <= tail_ff;
      else if (cmd.rel_commit) target_ff <= rslot_idx;
      if (cmd.advance) begin
         cur_ff       <= cur_ff + ADDR_W'(take_ff);
         remaining_ff <= rem_after;
         seg_n_ff     <= seg_n_ff + SEGN_W'(1);
      end
      if (cmd.emit) begin
         rsp_action_ff <= act_ff;
         rsp_line_ff   <= line_ff;
         rsp_off_ff    <= off_ff;
         rsp_take_ff   <= take_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_edev_ff   <= edev_ff;
         rsp_eline_ff  <= eline_ff;
         rsp_last_ff   <= st.last;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_action              = rsp_action_ff;
   assign rsp_line_number         = rsp_line_ff;
   assign rsp_offset_in_line      = rsp_off_ff;
   assign rsp_sector_take         = rsp_take_ff;
   assign rsp_slot_res            = rsp_slot_ff;
   assign rsp_evicted_device      = rsp_edev_ff;
   assign rsp_evicted_line_number = rsp_eline_ff;
   assign rsp_last_of_request     = rsp_last_ff;

   `ASSERT_IMPLY(a_emit_no_overwrite, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)
   `ASSERT_IMPLY(a_idle_list_count, clock, reset, cmd.load, recency_empty_ff == (lines_in_use_ff == '0))
   `ASSERT_NEXT(a_fill_counts, clock, reset, cmd.fill_free, lines_in_use_ff == $past(lines_in_use_ff) + SCAN_W'(1))

endmodule

// File: hw/rtl/lru_block_cache_tag_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_cache_tag_engine
// Tag and LRU replacement engine of a write-through sector cache.
// ----------------------------------------------------------------------------
// One request item yields one result per line segment (at most 33), in address
// order. Each item is first accepted and then decoded. A cached read or write
// segment scans every tag entry, one per cycle from the tag store's single read
// port, and then, on a hit, a write update, a fill or an eviction, updates the
// recency list. Each result is registered before it appears, and the engine
// holds while the result register is still full. After reset the block clears
// the valid bit of every tag entry before it accepts its first item; settings
// should be written only while no item is in flight.
module lru_block_cache_tag_engine
   import lbcte_pkg::*;
#(
   parameter int LINE_SLOTS          = 1024,
   parameter int DEVICE_COUNT        = 8,
   parameter int MAX_REQUEST_SECTORS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [DEV_W-1:0]      req_device,
   input  logic [ADDR_W-1:0]     req_start_sector,
   input  logic [CNT_W-1:0]      req_sector_count,
   input  logic [ADDR_W-1:0]     req_device_capacity,
   input  logic [SLOT_PW-1:0]    req_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_action,
   output logic [ADDR_W-1:0]     rsp_line_number,
   output logic [OFF_W-1:0]      rsp_offset_in_line,
   output logic [CNT_W-1:0]      rsp_sector_take,
   output logic [SLOT_PW-1:0]    rsp_slot_res,
   output logic [DEV_W-1:0]      rsp_evicted_device,
   output logic [ADDR_W-1:0]     rsp_evicted_line_number,
   output logic                  rsp_last_of_request,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   lbcte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lbcte_dpath #(
      .LINE_SLOTS          (LINE_SLOTS),
      .DEVICE_COUNT        (DEVICE_COUNT),
      .MAX_REQUEST_SECTORS (MAX_REQUEST_SECTORS)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .st                      (st),
      .req_opcode              (req_opcode),
      .req_device              (req_device),
      .req_start_sector        (req_start_sector),
      .req_sector_count        (req_sector_count),
      .req_device_capacity     (req_device_capacity),
      .req_slot                (req_slot),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_action              (rsp_action),
      .rsp_line_number         (rsp_line_number),
      .rsp_offset_in_line      (rsp_offset_in_line),
      .rsp_sector_take         (rsp_sector_take),
      .rsp_slot_res            (rsp_slot_res),
      .rsp_evicted_device      (rsp_evicted_device),
      .rsp_evicted_line_number (rsp_evicted_line_number),
      .rsp_last_of_request     (rsp_last_of_request),
      .csr_valid               (csr_valid),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the LRU block cache tag engine
// A short table of directed requests, then random reads, writes, releases and
// bad opcodes over a small pool of lines, across several register settings
// and idle mixes. Every result is compared field by field against a behavioral
// model of the tag store and recency list kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top
   import lbcte_pkg::*;
();

   localparam int SLOTS    = 1024;
   localparam int WD_LIMIT = 40000;

   typedef struct {
      logic [3:0]  act;
      logic [47:0] line;
      logic [6:0]  off;
      logic [9:0]  take;
      logic [9:0]  slot;
      logic [2:0]  edev;
      logic [47:0] eline;
      logic        last;
   } seg_type;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  dev;
      logic [47:0] start;
      logic [9:0]  cnt;
      logic [47:0] cap;
      logic [9:0]  slot;
      bit          chk;
      logic [3:0]  act;
   } row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   logic [2:0] req_device;
   logic [47:0] req_start_sector, req_device_capacity;
   logic [9:0] req_sector_count, req_slot;
   logic rsp_valid, rsp_ready;
   logic [3:0] rsp_action;
   logic [47:0] rsp_line_number, rsp_evicted_line_number;
   logic [6:0] rsp_offset_in_line;
   logic [9:0] rsp_sector_take, rsp_slot_res;
   logic [2:0] rsp_evicted_device;
   logic rsp_last_of_request;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [10:0] csr_wdata;

   lru_block_cache_tag_engine uut (.*);

   // model state
   bit          m_valid[SLOTS];
   logic [2:0]  m_dev[SLOTS];
   logic [47:0] m_line[SLOTS];
   int          m_prev[SLOTS], m_next[SLOTS];
   int          m_head, m_tail, m_used;
   bit          m_empty;
   bit          cfg_en;
   int          cfg_cap, cfg_shift;

   seg_type segs_pending[$];
   int   errors = 0, wd = 0, snd_pct = 0, rcv_pct = 0, n_items = 0, n_segs = 0;
   logic [47:0] pool[6];
   row_type dir_rows[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("error: %s got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic int fix(input int s);
      return (s >= 0 && s < SLOTS) ? s : 0;
   endfunction

   task automatic lru_unlink(input int s);
      if (m_head == s && m_tail == s) begin
         m_empty = 1;
         return;
      end
      if (s == m_head) m_head = fix(m_next[s]);
      else m_next[fix(m_prev[s])] = m_next[s];
      if (s == m_tail) m_tail = fix(m_prev[s]);
      else m_prev[fix(m_next[s])] = m_prev[s];
   endtask

   task automatic lru_push(input int s);
      if (m_empty) begin
         m_head = s;
         m_tail = s;
         m_empty = 0;
         return;
      end
      m_next[s] = m_head;
      m_prev[m_head] = s;
      m_head = s;
   endtask

   function automatic int tag_lookup(input logic [2:0] dev, input logic [47:0] line);
      for (int i = 0; i < SLOTS; i++)
         if (m_valid[i] && m_dev[i] == dev && m_line[i] == line) return i;
      return -1;
   endfunction

   // computes the segment results of one item and queues them
   task automatic predict_segments(input logic [1:0] op, input logic [2:0] dev,
                                   input logic [47:0] start, input logic [9:0] cnt,
                                   input logic [47:0] devcap, input logic [9:0] rslot,
                                   output logic [3:0] first_act);
      seg_type s[$];
      seg_type e;
      int sh, capl, hit, fr, v;
      logic [63:0] lsz, line, lstart, off, take, rem, cur;
      sh = cfg_shift < 4 ? 4 : cfg_shift;
      capl = cfg_cap > SLOTS ? SLOTS : cfg_cap;
      lsz = 64'd1 << sh;
      cur = 64'(start);
      rem = 64'(cnt);
      e = '{default: 0};
      if (op == OP_RELEASE) begin
         e.slot = rslot;
         if (m_valid[rslot]) begin
            lru_unlink(int'(rslot));
            m_valid[rslot] = 0;
            if (m_used > 0) m_used--;
            e.act = ACT_RELEASED;
         end else e.act = ACT_REJECTED;
         s.push_back(e);
      end else if (op == OP_BAD || cnt == 0 || cnt > 10'd512) begin
         e.act = ACT_REJECTED;
         s.push_back(e);
      end else begin
         while (rem > 0 && s.size() < 33) begin
            line = cur >> sh;
            lstart = line << sh;
            off = cur - lstart;
            take = lsz - off;
            if (take > rem) take = rem;
            e = '{default: 0};
            e.line = line[47:0];
            e.off = off[6:0];
            e.take = take[9:0];
            if (op == OP_WRITE) begin
               hit = cfg_en ? tag_lookup(dev, line[47:0]) : -1;
               if (hit >= 0) begin
                  lru_unlink(hit);
                  lru_push(hit);
                  e.act = ACT_WR_UPDATED;
                  e.slot = 10'(hit);
               end else e.act = ACT_WR_UNCACHED;
            end else if (!cfg_en) e.act = ACT_DIS_BYPASS;
            else if (devcap != 0 && lstart + lsz > {16'd0, devcap}) e.act = ACT_EDGE_BYPASS;
            else begin
               hit = tag_lookup(dev, line[47:0]);
               if (hit >= 0) begin
                  lru_unlink(hit);
                  lru_push(hit);
                  e.act = ACT_HIT;
                  e.slot = 10'(hit);
               end else begin
                  fr = -1;
                  if (m_used < capl)
                     for (int i = 0; i < SLOTS; i++)
                        if (!m_valid[i]) begin
                           fr = i;
                           break;
                        end
                  if (fr >= 0) begin
                     m_valid[fr] = 1;
                     m_dev[fr] = dev;
                     m_line[fr] = line[47:0];
                     m_used++;
                     lru_push(fr);
                     e.act = ACT_MISS_FREE;
                     e.slot = 10'(fr);
                  end else if (!m_empty) begin
                     v = m_tail;
                     e.edev = m_dev[v];
                     e.eline = m_line[v];
                     lru_unlink(v);
                     m_dev[v] = dev;
                     m_line[v] = line[47:0];
                     m_valid[v] = 1;
                     lru_push(v);
                     e.act = ACT_MISS_EVICT;
                     e.slot = 10'(v);
                  end else e.act = ACT_DIS_BYPASS;
               end
            end
            s.push_back(e);
            cur = (cur + take) & 64'hFFFF_FFFF_FFFF;
            rem = rem - take;
         end
      end
      first_act = s[0].act;
      for (int i = 0; i < s.size(); i++) begin
         e = s[i];
         e.last = (i == s.size() - 1);
         segs_pending.push_back(e);
      end
   endtask

   // called just after a falling edge; returns just after a falling edge
   task automatic send_item(input logic [1:0] op, input logic [2:0] dev,
                            input logic [47:0] start, input logic [9:0] cnt,
                            input logic [47:0] cap, input logic [9:0] slot,
                            output logic [3:0] first_act);
      while ($urandom_range(0, 99) < snd_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_opcode = op;
      req_device = dev;
      req_start_sector = start;
      req_sector_count = cnt;
      req_device_capacity = cap;
      req_slot = slot;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      predict_segments(op, dev, start, cnt, cap, slot, first_act);
      n_items++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 0;
      while (segs_pending.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [10:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE:   cfg_en = data[0];
         CSR_CAPACITY: cfg_cap = int'(data);
         CSR_SHIFT:    cfg_shift = int'(data[2:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_regs(input bit en, input int cap, input int sh);
      wait_idle();
      csr_write(CSR_ENABLE, 11'(en));
      csr_write(CSR_CAPACITY, 11'(cap));
      csr_write(CSR_SHIFT, 11'(sh));
   endtask

   task automatic random_item();
      logic [1:0] op;
      logic [2:0] dev;
      logic [47:0] start, cap;
      logic [9:0] cnt, slot;
      logic [3:0] fa;
      int k, r;
      r = $urandom_range(0, 99);
      dev = 3'($urandom_range(0, 7));
      slot = 10'($urandom_range(0, 1023));
      op = r < 55 ? OP_READ : (r < 80 ? OP_WRITE : (r < 95 ? OP_RELEASE : OP_BAD));
      if (op == OP_RELEASE && $urandom_range(0, 2) != 0) begin
         k = $urandom_range(0, SLOTS - 1);
         for (int i = 0; i < SLOTS; i++)
            if (m_valid[(k + i) % SLOTS]) begin
               slot = 10'((k + i) % SLOTS);
               break;
            end
      end
      if ($urandom_range(0, 9) == 0) start = 48'({$urandom, $urandom});
      else start = pool[$urandom_range(0, 5)] + 48'($urandom_range(0, 300));
      r = $urandom_range(0, 99);
      if (r < 70) cnt = 10'($urandom_range(1, 64));
      else if (r < 92) cnt = 10'($urandom_range(65, 200));
      else if (r < 96) cnt = 10'd0;
      else cnt = 10'($urandom_range(513, 1023));
      r = $urandom_range(0, 9);
      if (r < 6) cap = 48'd0;
      else if (r < 9) cap = start + 48'($urandom_range(0, 256));
      else cap = 48'({$urandom, $urandom});
      send_item(op, dev, start, cnt, cap, slot, fa);
   endtask

   // result checker
   always @(posedge clock) begin
      seg_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_segs++;
         if (segs_pending.size() == 0) begin
            report_mismatch("unexpected result action", 64'(rsp_action), 64'd0);
         end else begin
            e = segs_pending.pop_front();
            if (rsp_action !== e.act)
               report_mismatch("action", 64'(rsp_action), 64'(e.act));
            if (rsp_line_number !== e.line)
               report_mismatch("line", 64'(rsp_line_number), 64'(e.line));
            if (rsp_offset_in_line !== e.off)
               report_mismatch("offset", 64'(rsp_offset_in_line), 64'(e.off));
            if (rsp_sector_take !== e.take)
               report_mismatch("take", 64'(rsp_sector_take), 64'(e.take));
            if (rsp_slot_res !== e.slot)
               report_mismatch("slot", 64'(rsp_slot_res), 64'(e.slot));
            if (rsp_evicted_device !== e.edev)
               report_mismatch("evicted device", 64'(rsp_evicted_device), 64'(e.edev));
            if (rsp_evicted_line_number !== e.eline)
               report_mismatch("evicted line", 64'(rsp_evicted_line_number), 64'(e.eline));
            if (rsp_last_of_request !== e.last)
               report_mismatch("last", 64'(rsp_last_of_request), 64'(e.last));
         end
      end
   end

   always @(negedge clock) rsp_ready = ($urandom_range(0, 99) >= rcv_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         wd = 0;
      else wd++;
      if (wd >= WD_LIMIT) begin
         $display("timeout after %0d idle cycles", wd);
         $display("lru_block_cache_tag_engine: mismatch");
         $finish;
      end
   end

   initial begin
      logic [3:0] fa;
      int idle_snd[4];
      int idle_rcv[4];
      idle_snd = '{0, 49, 0, 38};
      idle_rcv = '{0, 0, 49, 38};
      reset = 1;
      req_valid = 0;
      req_opcode = OP_READ;
      req_device = 0;
      req_start_sector = 0;
      req_sector_count = 0;
      req_device_capacity = 0;
      req_slot = 0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_index = CSR_ENABLE;
      csr_wdata = 0;
      cfg_en = 1;
      cfg_cap = 1024;
      cfg_shift = 7;
      m_head = 0;
      m_tail = 0;
      m_used = 0;
      m_empty = 1;
      for (int i = 0; i < SLOTS; i++) begin
         m_valid[i] = 0;
         m_prev[i] = 0;
         m_next[i] = 0;
      end
      for (int i = 0; i < 6; i++) pool[i] = 48'({$urandom, $urandom}) & 48'h0000_0FFF_FF80;
      pool[0] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      dir_rows = '{
         '{OP_READ,    3'd0, 48'd0, 10'd1, 48'd0, 10'd0, 1'b1, ACT_MISS_FREE},
         '{OP_READ,    3'd0, 48'd0, 10'd1, 48'd0, 10'd0, 1'b1, ACT_HIT},
         '{OP_WRITE,   3'd0, 48'd5, 10'd3, 48'd0, 10'd0, 1'b1, ACT_WR_UPDATED},
         '{OP_WRITE,   3'd1, 48'd0, 10'd1, 48'd0, 10'd0, 1'b1, ACT_WR_UNCACHED},
         '{OP_READ,    3'd0, 48'd0, 10'd0, 48'd0, 10'd0, 1'b1, ACT_REJECTED},
         '{OP_READ,    3'd0, 48'd0, 10'd513, 48'd0, 10'd0, 1'b1, ACT_REJECTED},
         '{OP_BAD,     3'd2, 48'd9, 10'd4, 48'd0, 10'd3, 1'b1, ACT_REJECTED},
         '{OP_RELEASE, 3'd0, 48'd0, 10'd1, 48'd0, 10'd5, 1'b1, ACT_REJECTED},
         '{OP_RELEASE, 3'd0, 48'd0, 10'd1, 48'd0, 10'd0, 1'b1, ACT_RELEASED},
         '{OP_READ,    3'd7, 48'hFFFF_FFFF_FFFF, 10'd1, 48'd0, 10'd0, 1'b1, ACT_MISS_FREE},
         '{OP_READ,    3'd7, 48'hFFFF_FFFF_FFF5, 10'd40, 48'd0, 10'd0, 1'b0, ACT_HIT},
         '{OP_READ,    3'd2, 48'd100, 10'd50, 48'd120, 10'd0, 1'b1, ACT_EDGE_BYPASS},
         '{OP_READ,    3'd3, 48'd0, 10'd1, 48'hFFFF_FFFF_FFFF, 10'd0, 1'b0, ACT_HIT},
         '{OP_READ,    3'd4, 48'd1000, 10'd512, 48'd0, 10'd0, 1'b0, ACT_HIT},
         '{OP_WRITE,   3'd7, 48'hFFFF_FFFF_FFFF, 10'd1023, 48'd0, 10'd0, 1'b1, ACT_REJECTED},
         '{OP_RELEASE, 3'd0, 48'd0, 10'd0, 48'd0, 10'd1023, 1'b1, ACT_REJECTED},
         '{OP_WRITE,   3'd4, 48'd1100, 10'd200, 48'd0, 10'd0, 1'b0, ACT_HIT}
      };
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].op, dir_rows[i].dev, dir_rows[i].start, dir_rows[i].cnt,
                   dir_rows[i].cap, dir_rows[i].slot, fa);
         if (dir_rows[i].chk && fa !== dir_rows[i].act)
            report_mismatch("directed row action", 64'(fa), 64'(dir_rows[i].act));
      end

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: set_regs(1, 1024, 7);
            1: set_regs(1, 3, 4);
            2: set_regs(0, 2047, 5);
            3: set_regs(1, 0, 2);
            default: set_regs(1, 1024, 7);
         endcase
         snd_pct = idle_snd[p % 4];
         rcv_pct = idle_rcv[p % 4];
         if (p == 1) send_item(OP_READ, 3'd5, 48'd8, 10'd512, 48'd0, 10'd0, fa);
         if (p == 3) begin
            // empty the list so a zero-capacity miss finds no slot
            for (int i = 0; i < SLOTS; i++)
               if (m_valid[i]) send_item(OP_RELEASE, 3'd0, 48'd0, 10'd1, 48'd0, 10'(i), fa);
            send_item(OP_READ, 3'd6, 48'd64, 10'd20, 48'd0, 10'd0, fa);
         end
         repeat (15) random_item();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      $display("covered %0d items and %0d segment results over five register settings",
               n_items, n_segs);
      if (errors == 0 && segs_pending.size() == 0)
         $display("lru_block_cache_tag_engine: match");
      else
         $display("lru_block_cache_tag_engine: mismatch");
      $finish;
   end

endmodule

// File: lru_block_cache_tag_engine.f
+incdir+hw/rtl
hw/rtl/lbcte_pkg.sv
hw/rtl/lbcte_ctrl.sv
hw/rtl/lbcte_dpath.sv
hw/rtl/lru_block_cache_tag_engine.sv
sim/tb_top.sv
